@@ sv/scan_disk_scheduler_unit_assert.svh @@
// assertion macros used by the scheduler unit
`ifndef SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SDSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next one
`define SDSU_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ sv/sds_pkg.sv @@
package sds_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CYL_W        = 12;
    localparam int TOT_W        = 13;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;

    typedef logic [CYL_W-1:0] cyl_t;
    typedef logic [TOT_W-1:0] tot_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // handoff from one cell to the next one up the chain
    typedef struct packed {
        logic valid;
        logic gt;
        cyl_t value;
    } link_t;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic clr;
        cyl_t cyl;
        cyl_t head;
    } bcast_t;

endpackage

@@ sv/sds_cell.sv @@
module sds_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  sds_pkg::bcast_t bc,
    input  sds_pkg::link_t prev,
    output sds_pkg::link_t curr,
    output logic           le
);
    import sds_pkg::*;

    cyl_t value_reg;
    cyl_t value_next;
    logic valid_reg;
    logic valid_next;
    logic gt;
    logic load;

    // a cell moves up when its value exceeds the new item, or fills the first empty slot
    assign gt   = valid_reg && (value_reg > bc.cyl);
    assign load = bc.ins && (gt || (!valid_reg && prev.valid));

    always_comb begin
        value_next = value_reg;
        if (load) begin
            value_next = prev.gt ? prev.value : bc.cyl;
        end
        valid_next = valid_reg;
        if (bc.clr) begin
            valid_next = 1'b0;
        end else if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign curr.valid = valid_reg;
    assign curr.gt    = gt;
    assign curr.value = value_reg;
    assign le         = valid_reg && (value_reg <= bc.head);

endmodule

@@ sv/scan_disk_scheduler_unit.sv @@
// SCAN disk scheduler, head first moving toward cylinder 0. Requests stream in on the s_ side
// one item per cycle in the load state and are insertion-sorted into a row of MAX_REQUESTS
// cells in the cycle they arrive; requests beyond a full row are dropped, though a dropped item
// marked last still closes the batch. After the last item the head (cfg_wdata, taken by cfg_we,
// which the user must raise only while idle, as the block does not enforce it, and sampled when
// the last item arrives) splits the sorted row, then the results leave on the m_ side at one
// item per cycle while the output is not stalled: requests at or below the head in descending
// order, the turn at cylinder 0, then requests above the head in ascending order, n + 1 results
// for n stored requests. The final result carries tlast and the total movement (head plus the
// largest request above it, or the head alone). A batch thus passes the load state, a split
// step and the emit walk, one cell read per cycle; output stalls stretch only the emit walk.
// Loading of the next batch starts once the final result is in the output register.
module scan_disk_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: head position
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] cylinder, [15:12] zero
    input  logic        s_tlast,   // last request of the batch
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] served_cylinder, [24:12] total_movement, [31:25] zero
    output logic        m_tlast    // end_of_run
);
    import sds_pkg::*;

    `include "scan_disk_scheduler_unit_assert.svh"

    // sequencer states
    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,   // taking requests
        S_PREP = 5'b00010,   // find the split at the head
        S_LO   = 5'b00100,   // walk down through requests at or below head
        S_TURN = 5'b01000,   // the turn at cylinder 0
        S_HI   = 5'b10000    // walk up through requests above head
    } state_t;

    state_t state_reg, state_next;

    cyl_t   head_cfg_reg;
    cyl_t   head_reg, head_next;
    cnt_t   count_reg, count_next;
    cnt_t   split_reg, split_next;
    cnt_t   ptr_reg, ptr_next;
    cnt_t   split_calc;

    logic   out_valid_reg, out_valid_next;
    cyl_t   out_cyl_reg, out_cyl_next;
    tot_t   out_tot_reg, out_tot_next;
    logic   out_last_reg, out_last_next;

    logic   in_acc;
    logic   full;
    logic   out_free;
    logic   emit;
    logic   emit_final;
    cyl_t   rd_value;

    bcast_t bc;
    link_t  lnk [MAX_REQUESTS+1];
    cyl_t   cell_val [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] le_vec;
    logic [MAX_REQUESTS-1:0] valid_vec;

    assign in_acc   = s_tvalid && s_tready;
    assign full     = (count_reg == cnt_t'(MAX_REQUESTS));
    assign out_free = !out_valid_reg || m_tready;

    // broadcast into the cell row
    assign bc.ins  = in_acc && !full;
    assign bc.clr  = emit_final;
    assign bc.cyl  = s_tdata[CYL_W-1:0];
    assign bc.head = head_reg;

    // bottom of the chain: an always-valid, never-greater neighbor
    assign lnk[0] = '{valid: 1'b1, gt: 1'b0, value: '0};

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        sds_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bc      (bc),
            .prev    (lnk[g]),
            .curr    (lnk[g+1]),
            .le      (le_vec[g])
        );
        assign cell_val[g]  = lnk[g+1].value;
        assign valid_vec[g] = lnk[g+1].valid;
    end

    // split = number of stored requests at or below the head; le is a prefix of the row
    always_comb begin
        split_calc = '0;
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            if (le_vec[i] && ((i == MAX_REQUESTS - 1) || !le_vec[(i + 1) % MAX_REQUESTS])) begin
                split_calc = split_calc | cnt_t'(i + 1);
            end
        end
    end

    // emit walk reads one cell per cycle while the output is free
    assign rd_value = cell_val[ptr_reg[IDX_W-1:0]];

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        split_next     = split_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cyl_next   = out_cyl_reg;
        out_tot_next   = out_tot_reg;
        out_last_next  = out_last_reg;
        emit           = 1'b0;
        emit_final     = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (in_acc) begin
                    if (!full) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        head_next  = head_cfg_reg;
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP: begin
                split_next = split_calc;
                if (split_calc != '0) begin
                    ptr_next   = split_calc - 1'b1;
                    state_next = S_LO;
                end else begin
                    state_next = S_TURN;
                end
            end
            S_LO: begin
                if (out_free) begin
                    emit         = 1'b1;
                    out_cyl_next = rd_value;
                    out_tot_next = '0;
                    if (ptr_reg == '0) begin
                        state_next = S_TURN;
                    end else begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
            end
            S_TURN: begin
                if (out_free) begin
                    emit         = 1'b1;
                    out_cyl_next = '0;
                    out_tot_next = '0;
                    if (split_reg == count_reg) begin
                        // nothing above the head
                        emit_final   = 1'b1;
                        out_tot_next = {1'b0, head_reg};
                        state_next   = S_LOAD;
                    end else begin
                        ptr_next   = split_reg;
                        state_next = S_HI;
                    end
                end
            end
            S_HI: begin
                if (out_free) begin
                    emit         = 1'b1;
                    out_cyl_next = rd_value;
                    out_tot_next = '0;
                    if (ptr_reg == count_reg - 1'b1) begin
                        // top of the row is the largest request above the head
                        emit_final   = 1'b1;
                        out_tot_next = {1'b0, head_reg} + {1'b0, rd_value};
                        state_next   = S_LOAD;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
            out_last_next  = emit_final;
        end
        if (emit_final) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            head_cfg_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                head_cfg_reg <= cfg_wdata;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        split_reg    <= split_next;
        ptr_reg      <= ptr_next;
        out_cyl_reg  <= out_cyl_next;
        out_tot_reg  <= out_tot_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_tot_reg, out_cyl_reg};
    assign m_tlast  = out_last_reg;

    // count tracks the filled cells
    `SDSU_ASSERT(a_count_cells, $countones(valid_vec) == 32'(count_reg), "count and cell row disagree")
    // fill level stays within the row
    `SDSU_ASSERT(a_count_bound, count_reg <= cnt_t'(MAX_REQUESTS), "count beyond the row")
    // the last request always leads to the split step
    `SDSU_ASSERT_NEXT(a_last_prep, in_acc && s_tlast, state_reg == S_PREP, "last item not split")
    // the final result empties the row and carries tlast
    `SDSU_ASSERT_NEXT(a_final_clear, emit_final, (count_reg == '0) && m_tvalid && m_tlast,
        "batch not closed after final result")

endmodule

@@ tb/sv/scan_order_check_pkg.sv @@
`timescale 1ns / 100ps
package scan_order_check_pkg;
    import sds_pkg::*;

    // one expected result item
    typedef struct packed {
        cyl_t served;
        tot_t total;
        logic end_of_run;
    } visit_t;

    class scan_order_board;
        cyl_t   head;
        cyl_t   loaded[$];   // requests of the open batch, ascending
        visit_t visits[$];   // expected results, oldest first
        int     fail_count;

        function new();
            head       = '0;
            fail_count = 0;
        endfunction

        function void set_head(cyl_t h);
            head = h;
        endfunction

        function int pending();
            return visits.size();
        endfunction

        // store one request; the last one of a batch yields the whole sweep
        function void note_request(cyl_t cyl, logic last);
            int     pos;
            int     split;
            cyl_t   order[$];
            cyl_t   top;
            logic   any_above;
            tot_t   total_mv;
            visit_t v;
            if (loaded.size() < MAX_REQUESTS) begin
                pos = 0;
                while (pos < loaded.size() && loaded[pos] <= cyl)
                    pos++;
                loaded.insert(pos, cyl);
            end
            if (!last)
                return;
            split = 0;
            while (split < loaded.size() && loaded[split] <= head)
                split++;
            for (int i = split - 1; i >= 0; i--)
                order.push_back(loaded[i]);
            order.push_back('0);
            any_above = 1'b0;
            top       = '0;
            for (int i = split; i < loaded.size(); i++) begin
                order.push_back(loaded[i]);
                top       = loaded[i];
                any_above = 1'b1;
            end
            total_mv = tot_t'(head);
            if (any_above)
                total_mv = total_mv + tot_t'(top);
            for (int i = 0; i < order.size(); i++) begin
                v.served     = order[i];
                v.total      = (i == order.size() - 1) ? total_mv : '0;
                v.end_of_run = (i == order.size() - 1);
                visits.push_back(v);
            end
            loaded.delete();
        endfunction

        function void report(string what);
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void check_result(cyl_t cyl, tot_t tot, logic eor);
            visit_t want;
            if (visits.size() == 0) begin
                report($sformatf("result with nothing pending: cylinder %0d total %0d end %0b",
                                 cyl, tot, eor));
                return;
            end
            want = visits.pop_front();
            if (want.served !== cyl)
                report($sformatf("served_cylinder expected %0d got %0d", want.served, cyl));
            if (want.total !== tot)
                report($sformatf("total_movement expected %0d got %0d", want.total, tot));
            if (want.end_of_run !== eor)
                report($sformatf("end_of_run expected %0b got %0b", want.end_of_run, eor));
        endfunction
    endclass

endpackage

@@ tb/sv/scan_disk_scheduler_unit_test.sv @@
`timescale 1ns / 100ps
module scan_disk_scheduler_unit_test;
    import sds_pkg::*;
    import scan_order_check_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT  = 400000;
    // cycles the receiver holds off when asked to
    localparam int HOLD_CYCLES  = 240;
    // least number of random request items per phase
    localparam int PHASE_ITEMS  = 85;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [11:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] cylinder, [15:12] zero
    logic        s_tlast;   // last request of the batch
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [11:0] served_cylinder, [24:12] total_movement, [31:25] zero
    logic        m_tlast;   // end_of_run

    scan_order_board board;

    int   send_idle_pct;    // chance in a hundred that the sender idles a cycle
    int   recv_stall_pct;   // chance in a hundred that the receiver stalls a cycle
    int   hold_requests;    // long hold-offs asked of the receiver so far
    cyl_t batch_q[$];       // requests of the batch about to be sent
    cyl_t prev_cyl;         // last random cylinder, reused for duplicates

    scan_disk_scheduler_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: a correct run ends long before this
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("scan_disk_scheduler_unit verification failed");
        $finish;
    end

    // result side ready, changed on the falling edge only
    initial begin : receiver
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            // the long hold-off is counted here, independent of the sender
            if (hold_requests != hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = hold_requests;
            end
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // every accepted result item is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata[11:0], m_tdata[24:12], m_tlast);
    end

    // offer one request, with random idle cycles first; returns once accepted
    task automatic send_request(input cyl_t cyl, input logic last);
        cyl_t noise;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            // junk on the data lines while valid is low
            noise    = cyl_t'($urandom_range(4095));
            s_tvalid = 1'b0;
            s_tdata  = {4'b0, noise};
            s_tlast  = 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, cyl};
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_request(cyl, last);
    endtask

    // drop valid after the last accepted item
    task automatic sender_rest;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // sender pauses until every pending result has come
    task automatic wait_drained;
        sender_rest();
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // head is only rewritten with the block idle and no batch open
    task automatic write_head(input cyl_t h);
        wait_drained();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = h;
        @(negedge aclk);
        cfg_we    = 1'b0;
        board.set_head(h);
    endtask

    task automatic send_batch;
        for (int i = 0; i < batch_q.size(); i++)
            send_request(batch_q[i], i == batch_q.size() - 1);
    endtask

    // mostly short batches; now and then one that overflows the store,
    // so that the closing request is dropped yet still ends the batch
    task automatic build_random_batch;
        int   len;
        cyl_t c;
        batch_q.delete();
        if ($urandom_range(11) == 0)
            len = $urandom_range(40, 33);
        else
            len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: c = '0;
                1: c = '1;
                2: c = board.head;                                       // equal to head
                3: c = cyl_t'(board.head + $urandom_range(6) - 3);       // around the head
                4: c = prev_cyl;                                         // duplicate
                default: c = cyl_t'($urandom_range(4095));
            endcase
            prev_cyl = c;
            batch_q.push_back(c);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input cyl_t phase_head,
                             input bit with_hold);
        int phase_items;
        write_head(phase_head);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // receiver holds off while the sender keeps going, so the block fills
        // and has to stall its input
        if (with_hold)
            hold_requests = hold_requests + 1;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            build_random_batch();
            send_batch();
            phase_items = phase_items + batch_q.size();
            // keep the first batches of a phase back to back
            if (phase_items >= 30) begin
                case ($urandom_range(7))
                    0: write_head(cyl_t'($urandom_range(4095)));
                    1: wait_drained();
                    default: ;
                endcase
            end
        end
    endtask

    initial begin
        board     = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        prev_cyl  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part, no idling
        // head still at its reset value of 0
        batch_q = {12'd5, 12'd0, 12'd4095};
        send_batch();
        // request equal to head, duplicates, both extremes
        write_head(12'd2000);
        batch_q = {12'd2000, 12'd4095, 12'd0, 12'd2000, 12'd1500};
        send_batch();
        // only one request, above the head
        batch_q = {12'd4095};
        send_batch();
        // only one request, at cylinder 0
        batch_q = {12'd0};
        send_batch();
        // head at the top: nothing can lie above it
        write_head(12'd4095);
        batch_q = {12'd4095, 12'd0, 12'd4095, 12'd1};
        send_batch();
        batch_q = {12'd4094, 12'd7, 12'd7};
        send_batch();

        // random part: no idling with a long hold-off, sender idling,
        // receiver stalling, then both
        run_phase(0, 0, 12'd4095, 1'b1);
        run_phase(61, 0, 12'd0, 1'b0);
        run_phase(0, 61, cyl_t'($urandom_range(4095)), 1'b0);
        run_phase(20, 20, 12'd2048, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (board.fail_count == 0) begin
            $display("scan_disk_scheduler_unit verification clean");
        end else begin
            $display("scan_disk_scheduler_unit verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sds_pkg.sv
sv/sds_cell.sv
sv/scan_disk_scheduler_unit.sv
tb/sv/scan_order_check_pkg.sv
tb/sv/scan_disk_scheduler_unit_test.sv
